@@ hdl/dsvm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvm_pkg
// shared field widths, request kinds and control structs of the voice mixer
// ----------------------------------------------------------------------------
package dsvm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int INST_W      = 4;
  localparam int ADDR_FW     = 14;
  localparam int LEN_W       = 15;
  localparam int POS_W       = LEN_W + 1;
  localparam int MASK_BITS   = 9;
  localparam int MASK_IW     = $clog2(MASK_BITS);
  localparam int OUT_CNT_W   = 5;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_DESC  = 2'd1,
    FUNC_TRIG  = 2'd2,
    FUNC_FRAME = 2'd3
  } func_t;

  typedef struct packed {
    func_t                   func;
    logic [INST_W-1:0]       instrument;
    logic [ADDR_FW-1:0]      address;
    logic [SAMPLE_BITS-1:0]  sample_value;
    logic [LEN_W-1:0]        length;
    logic                    stereo;
    logic [MASK_BITS-1:0]    trigger_mask;
  } item_t;

  typedef struct packed {
    logic clr;
    logic add_l;
    logic add_r;
    logic done;
  } mix_ctl_t;

endpackage

@@ hdl/dsvm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvm_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dsvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/dsvm_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvm_seq
// request sequencer: sample loads, descriptors, voice allocation and the
// per-frame read-modify-write walk over the voice table
// ----------------------------------------------------------------------------
module dsvm_seq #(
  parameter int NUM_INSTRUMENTS  = 9,
  parameter int MAX_VOICES       = 16,
  parameter int INSTRUMENT_WORDS = 16384,
  localparam int SADDR_W = (NUM_INSTRUMENTS * INSTRUMENT_WORDS > 1) ?
                           $clog2(NUM_INSTRUMENTS * INSTRUMENT_WORDS) : 1,
  localparam int VW      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1,
  localparam int CW      = $clog2(MAX_VOICES + 1),
  localparam int VRAM_W  = dsvm_pkg::INST_W + dsvm_pkg::POS_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dsvm_pkg::item_t                  in_item,
  output logic                             samp_we,
  output logic [SADDR_W-1:0]               samp_waddr,
  output logic [dsvm_pkg::SAMPLE_BITS-1:0] samp_wdata,
  output logic                             samp_re,
  output logic [SADDR_W-1:0]               samp_raddr,
  output logic                             voice_we,
  output logic [VW-1:0]                    voice_waddr,
  output logic [VRAM_W-1:0]                voice_wdata,
  output logic                             voice_re,
  output logic [VW-1:0]                    voice_raddr,
  input  logic [VRAM_W-1:0]                voice_rdata,
  output dsvm_pkg::mix_ctl_t               mix_ctl,
  input  logic                             out_free,
  output logic [CW-1:0]                    active_cnt,
  output logic                             overflow
);

  import dsvm_pkg::*;

  localparam int NIW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_TRIG, S_FADDR, S_FVOICE, S_FWORDA, S_FWORDB, S_FDONE
  } state_t;

  state_t                state;
  logic [LEN_W-1:0]      len_q [NUM_INSTRUMENTS];
  logic                  st_q [NUM_INSTRUMENTS];
  logic [MAX_VOICES-1:0] valid_q;
  logic                  ovf_q;
  logic [MASK_BITS-1:0]  mask_q;
  logic [INST_W:0]       icnt;
  logic [CW-1:0]         vcnt;
  logic [CW-1:0]         count_q;
  logic [INST_W-1:0]     cur_ins;
  logic [POS_W-1:0]      cur_pos;
  logic [LEN_W-1:0]      cur_lim;
  logic                  cur_st;
  logic [SADDR_W-1:0]    samp_addr_q;

  logic                  acc;
  logic                  in_inst_ok;
  logic                  in_addr_ok;
  logic [LEN_W-1:0]      len_sat;
  logic [VW-1:0]         v_idx;
  logic                  v_end;
  logic                  i_end;
  logic                  want;
  logic                  alloc;
  logic [INST_W-1:0]     rd_ins;
  logic [POS_W-1:0]      rd_pos;
  logic                  ins_ok;
  logic [LEN_W-1:0]      lim_sel;
  logic                  st_sel;
  logic                  pos_lt;
  logic [SADDR_W-1:0]    base_addr;
  logic                  b_needed;
  logic [POS_W-1:0]      new_pos;
  logic                  wb;

  assign in_ready   = (state == S_IDLE);
  assign acc        = in_valid && in_ready;
  assign in_inst_ok = ({1'b0, in_item.instrument} < (INST_W + 1)'(NUM_INSTRUMENTS));
  assign in_addr_ok = (32'(in_item.address) < INSTRUMENT_WORDS);
  assign len_sat    = (32'(in_item.length) > INSTRUMENT_WORDS) ?
                      LEN_W'(INSTRUMENT_WORDS) : in_item.length;

  assign v_idx = vcnt[VW-1:0];
  assign v_end = (vcnt == CW'(MAX_VOICES));
  assign i_end = (icnt == (INST_W + 1)'(NUM_INSTRUMENTS));
  assign want  = (icnt < (INST_W + 1)'(MASK_BITS)) && mask_q[icnt[MASK_IW-1:0]] &&
                 (len_q[icnt[NIW-1:0]] != '0);
  assign alloc = (state == S_TRIG) && !i_end && want && !v_end && !valid_q[v_idx];

  assign rd_ins    = voice_rdata[VRAM_W-1 -: INST_W];
  assign rd_pos    = voice_rdata[POS_W-1:0];
  assign ins_ok    = ({1'b0, rd_ins} < (INST_W + 1)'(NUM_INSTRUMENTS));
  assign lim_sel   = ins_ok ? len_q[rd_ins[NIW-1:0]] : '0;
  assign st_sel    = ins_ok ? st_q[rd_ins[NIW-1:0]] : 1'b0;
  assign pos_lt    = (rd_pos < {1'b0, lim_sel});
  assign base_addr = SADDR_W'(rd_ins) * SADDR_W'(INSTRUMENT_WORDS) + SADDR_W'(rd_pos);

  assign b_needed = cur_st && ((cur_pos + POS_W'(1)) < {1'b0, cur_lim});
  assign new_pos  = cur_st ? (cur_pos + POS_W'(2)) : (cur_pos + POS_W'(1));
  assign wb       = ((state == S_FWORDA) && !b_needed) || (state == S_FWORDB);

  // sample memory port
  assign samp_we    = acc && (in_item.func == FUNC_LOAD) && in_inst_ok && in_addr_ok;
  assign samp_waddr = SADDR_W'(in_item.instrument) * SADDR_W'(INSTRUMENT_WORDS) +
                      SADDR_W'(in_item.address);
  assign samp_wdata = in_item.sample_value;
  assign samp_re    = ((state == S_FVOICE) && ins_ok && pos_lt) ||
                      ((state == S_FWORDA) && b_needed);
  assign samp_raddr = (state == S_FWORDA) ? (samp_addr_q + SADDR_W'(1)) : base_addr;

  // voice table port
  assign voice_re    = (state == S_FADDR) && !v_end && valid_q[v_idx];
  assign voice_raddr = v_idx;
  assign voice_we    = alloc || wb;
  assign voice_waddr = v_idx;
  assign voice_wdata = alloc ? {icnt[INST_W-1:0], POS_W'(0)} : {cur_ins, new_pos};

  assign mix_ctl.clr   = acc && (in_item.func == FUNC_FRAME);
  assign mix_ctl.add_l = (state == S_FWORDA);
  assign mix_ctl.add_r = ((state == S_FWORDA) && !cur_st) || (state == S_FWORDB);
  assign mix_ctl.done  = (state == S_FDONE) && out_free;

  assign active_cnt = count_q;
  assign overflow   = ovf_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      len_q   <= '{default: '0};
      st_q    <= '{default: 1'b0};
      valid_q <= '0;
      ovf_q   <= 1'b0;
      icnt    <= '0;
      vcnt    <= '0;
      count_q <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            unique case (in_item.func)
              FUNC_LOAD: begin
              end
              FUNC_DESC: begin
                if (in_inst_ok) begin
                  len_q[in_item.instrument[NIW-1:0]] <= len_sat;
                  st_q[in_item.instrument[NIW-1:0]]  <= in_item.stereo;
                end
              end
              FUNC_TRIG: begin
                mask_q <= in_item.trigger_mask;
                icnt   <= '0;
                vcnt   <= '0;
                state  <= S_TRIG;
              end
              FUNC_FRAME: begin
                vcnt    <= '0;
                count_q <= '0;
                state   <= S_FADDR;
              end
              default: begin
              end
            endcase
          end
        end
        S_TRIG: begin
          if (i_end) begin
            state <= S_IDLE;
          end else if (!want) begin
            icnt <= icnt + 1'b1;
          end else if (v_end) begin
            ovf_q <= 1'b1;
            icnt  <= icnt + 1'b1;
          end else if (!valid_q[v_idx]) begin
            valid_q[v_idx] <= 1'b1;
            icnt           <= icnt + 1'b1;
            vcnt           <= vcnt + 1'b1;
          end else begin
            vcnt <= vcnt + 1'b1;
          end
        end
        S_FADDR: begin
          if (v_end) begin
            state <= S_FDONE;
          end else if (!valid_q[v_idx]) begin
            vcnt <= vcnt + 1'b1;
          end else begin
            state <= S_FVOICE;
          end
        end
        S_FVOICE: begin
          cur_ins     <= rd_ins;
          cur_pos     <= rd_pos;
          cur_lim     <= lim_sel;
          cur_st      <= st_sel;
          samp_addr_q <= base_addr;
          if (!ins_ok || !pos_lt) begin
            valid_q[v_idx] <= 1'b0;
            vcnt           <= vcnt + 1'b1;
            state          <= S_FADDR;
          end else begin
            state <= S_FWORDA;
          end
        end
        S_FWORDA, S_FWORDB: begin
          if (wb) begin
            if (new_pos >= {1'b0, cur_lim}) begin
              valid_q[v_idx] <= 1'b0;
            end else begin
              count_q <= count_q + 1'b1;
            end
            vcnt  <= vcnt + 1'b1;
            state <= S_FADDR;
          end else begin
            state <= S_FWORDB;
          end
        end
        S_FDONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/dsvm_mix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvm_mix
// left/right accumulators, q1.15 saturation and the result output register
// ----------------------------------------------------------------------------
module dsvm_mix #(
  parameter int MAX_VOICES = 16,
  localparam int CW = $clog2(MAX_VOICES + 1)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  dsvm_pkg::mix_ctl_t                      ctl,
  input  logic signed [dsvm_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [CW-1:0]                           active_cnt,
  input  logic                                    overflow,
  output logic                                    out_free,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [39:0]                             m_axis_tdata
);

  import dsvm_pkg::*;

  localparam int ACC_W = SAMPLE_BITS + ((MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 0) + 1;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;
  logic [CW+OUT_CNT_W-1:0] cnt_wide;

  function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic [SAMPLE_BITS-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign cnt_wide = (CW + OUT_CNT_W)'(active_cnt);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_l <= '0;
      acc_r <= '0;
    end else begin
      if (ctl.add_l) begin
        acc_l <= acc_l + ACC_W'(sample);
      end
      if (ctl.add_r) begin
        acc_r <= acc_r + ACC_W'(sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.done) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {2'b00, overflow, cnt_wide[OUT_CNT_W-1:0], sat(acc_r), sat(acc_l)};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

@@ hdl/drum_sample_voice_mixer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_sample_voice_mixer_top
// polyphonic drum sample player and saturating stereo mixer
//
// load and descriptor requests are taken in the idle state
// trigger requests walk the instruments, allocating free voice slots
// frame requests walk every voice slot, reading two samples per stereo voice with a full
// pair, one per other playing voice and none per voice already past its length
// the result waits in an output register; a later frame holds until it is taken
// reset clears voices, descriptors and the overflow flag; sample memory is kept
// ----------------------------------------------------------------------------
module drum_sample_voice_mixer_top #(
  parameter int NUM_INSTRUMENTS  = 9,
  parameter int MAX_VOICES       = 16,
  parameter int INSTRUMENT_WORDS = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // func
  // instrument, address, sample_value, length, stereo, trigger_mask
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left, right, active_voices, voice_overflow
  output logic [39:0] m_axis_tdata
);

  import dsvm_pkg::*;

  localparam int SDEPTH  = NUM_INSTRUMENTS * INSTRUMENT_WORDS;
  localparam int SADDR_W = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int VW      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW      = $clog2(MAX_VOICES + 1);
  localparam int VRAM_W  = INST_W + POS_W;

  item_t                   item;
  logic                    samp_we;
  logic [SADDR_W-1:0]      samp_waddr;
  logic [SAMPLE_BITS-1:0]  samp_wdata;
  logic                    samp_re;
  logic [SADDR_W-1:0]      samp_raddr;
  logic [SAMPLE_BITS-1:0]  samp_rdata;
  logic                    voice_we;
  logic [VW-1:0]           voice_waddr;
  logic [VRAM_W-1:0]       voice_wdata;
  logic                    voice_re;
  logic [VW-1:0]           voice_raddr;
  logic [VRAM_W-1:0]       voice_rdata;
  mix_ctl_t                mix_ctl;
  logic                    out_free;
  logic [CW-1:0]           active_cnt;
  logic                    overflow;

  assign item.func         = func_t'(s_axis_tuser);
  assign item.instrument   = s_axis_tdata[3:0];
  assign item.address      = s_axis_tdata[17:4];
  assign item.sample_value = s_axis_tdata[33:18];
  assign item.length       = s_axis_tdata[48:34];
  assign item.stereo       = s_axis_tdata[49];
  assign item.trigger_mask = s_axis_tdata[58:50];

  dsvm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (SDEPTH)
  ) u_samp_ram (
    .clk   (clk),
    .we    (samp_we),
    .waddr (samp_waddr),
    .wdata (samp_wdata),
    .re    (samp_re),
    .raddr (samp_raddr),
    .rdata (samp_rdata)
  );

  dsvm_ram #(
    .WIDTH (VRAM_W),
    .DEPTH (MAX_VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (voice_we),
    .waddr (voice_waddr),
    .wdata (voice_wdata),
    .re    (voice_re),
    .raddr (voice_raddr),
    .rdata (voice_rdata)
  );

  dsvm_seq #(
    .NUM_INSTRUMENTS  (NUM_INSTRUMENTS),
    .MAX_VOICES       (MAX_VOICES),
    .INSTRUMENT_WORDS (INSTRUMENT_WORDS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_item     (item),
    .samp_we     (samp_we),
    .samp_waddr  (samp_waddr),
    .samp_wdata  (samp_wdata),
    .samp_re     (samp_re),
    .samp_raddr  (samp_raddr),
    .voice_we    (voice_we),
    .voice_waddr (voice_waddr),
    .voice_wdata (voice_wdata),
    .voice_re    (voice_re),
    .voice_raddr (voice_raddr),
    .voice_rdata (voice_rdata),
    .mix_ctl     (mix_ctl),
    .out_free    (out_free),
    .active_cnt  (active_cnt),
    .overflow    (overflow)
  );

  dsvm_mix #(
    .MAX_VOICES (MAX_VOICES)
  ) u_mix (
    .clk           (clk),
    .rst           (rst),
    .ctl           (mix_ctl),
    .sample        (samp_rdata),
    .active_cnt    (active_cnt),
    .overflow      (overflow),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ hdl/dsvm_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsvm_check
// port-level checks of the voice mixer, bound to the top level
// ----------------------------------------------------------------------------
module dsvm_check #(
  parameter int MAX_VOICES = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  import dsvm_pkg::*;

  logic       frame_req;
  logic       out_req;
  logic [2:0] pend;
  logic       ovf_seen;

  assign frame_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_FRAME);
  assign out_req   = m_axis_tvalid && m_axis_tready;

  // frame requests not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      ovf_seen <= 1'b0;
    end else begin
      pend <= pend + {2'b00, frame_req} - {2'b00, out_req};
      if (out_req && m_axis_tdata[37]) begin
        ovf_seen <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_out_has_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pend != 3'd0)
    else $error("result without a frame request");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ovf_seen |-> m_axis_tdata[37])
    else $error("overflow flag cleared");

  a_active_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (MAX_VOICES > 31) || (m_axis_tdata[36:32] <= MAX_VOICES))
    else $error("active voice count out of range");

endmodule

bind drum_sample_voice_mixer_top dsvm_check #(
  .MAX_VOICES (MAX_VOICES)
) u_dsvm_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
